// ----- rtl/core/char_lcd_nibble_sequencer_macros.svh -----
// Assertion macros shared by the character-LCD nibble sequencer RTL.
// No dependencies; each file that asserts includes this header.
`ifndef CHAR_LCD_NIBBLE_SEQUENCER_MACROS_SVH
`define CHAR_LCD_NIBBLE_SEQUENCER_MACROS_SVH

// Checked on every rising clk edge, off while rst_n is low.
`define LCDNS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising clk edge, reset included.
`define LCDNS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/core/lcdns_pkg.sv -----
// Package for the character-LCD nibble sequencer: command codes, queue
// descriptor and strobe types, timing constants and the init table.
// No dependencies.
`timescale 1ns / 1ps

package lcdns_pkg;

    typedef enum logic [2:0] {
        CMD_INIT    = 3'd0,
        CMD_BYTE    = 3'd1,
        CMD_CHAR    = 3'd2,
        CMD_GOTO    = 3'd3,
        CMD_CLEAR   = 3'd4,
        CMD_CHAR_AT = 3'd5
    } cmd_t;

    localparam int QUEUE_DEPTH = 2;
    localparam int STEP_W      = 4;

    localparam logic [STEP_W-1:0] LAST_STEP_INIT = 4'd11;
    localparam logic [STEP_W-1:0] LAST_STEP_PAIR = 4'd3;
    localparam logic [STEP_W-1:0] LAST_STEP_BYTE = 4'd1;

    localparam logic [7:0] BYTE_CLEAR = 8'h01;
    localparam logic [7:0] ADDR_BASE  = 8'h80;

    localparam logic [14:0] WAIT_POWERUP  = 15'd20000;
    localparam logic [14:0] WAIT_BYTE_PRE = 15'd40;
    localparam logic [14:0] WAIT_NONE_PRE = 15'd0;
    localparam logic [12:0] WAIT_STROBE   = 13'd200;
    localparam logic [12:0] WAIT_CLEAR    = 13'd2200;
    localparam logic [12:0] WAIT_WAKE     = 13'd5000;

    // One queued request, already classified by the front end.
    typedef struct packed {
        logic       is_init;
        logic       two_bytes;  // address byte then character byte
        logic       clr_wait;   // clear: long wait after the low nibble
        logic       rs0;
        logic [7:0] byte0;
        logic [7:0] byte1;      // character of a positioned write, rs = 1
    } desc_t;

    typedef struct packed {
        logic        rs;
        logic [3:0]  nibble;
        logic [14:0] wait_before;
        logic [12:0] wait_after;
    } strobe_t;

    // Power-up sequence: wake nibbles 3,3,3,2 then bytes 0x28, 0x01, 0x06, 0x0C.
    function automatic strobe_t init_strobe(input logic [STEP_W-1:0] step);
        strobe_t s;
        s.rs          = 1'b0;
        s.wait_before = WAIT_NONE_PRE;
        s.wait_after  = WAIT_STROBE;
        case (step)
            4'd0:
            begin
                s.nibble      = 4'h3;
                s.wait_before = WAIT_POWERUP;
                s.wait_after  = WAIT_WAKE;
            end
            4'd1:    s.nibble = 4'h3;
            4'd2:    s.nibble = 4'h3;
            4'd3:
            begin
                s.nibble     = 4'h2;
                s.wait_after = WAIT_WAKE;
            end
            4'd4:
            begin
                s.nibble      = 4'h2;
                s.wait_before = WAIT_BYTE_PRE;
            end
            4'd5:    s.nibble = 4'h8;
            4'd6:
            begin
                s.nibble      = 4'h0;
                s.wait_before = WAIT_BYTE_PRE;
            end
            4'd7:
            begin
                s.nibble     = 4'h1;
                s.wait_after = WAIT_CLEAR;
            end
            4'd8:
            begin
                s.nibble      = 4'h0;
                s.wait_before = WAIT_BYTE_PRE;
            end
            4'd9:    s.nibble = 4'h6;
            4'd10:
            begin
                s.nibble      = 4'h0;
                s.wait_before = WAIT_BYTE_PRE;
            end
            4'd11:   s.nibble = 4'hC;
            default: s.nibble = 4'h0;
        endcase
        return s;
    endfunction

endpackage

// ----- rtl/core/lcdns_front.sv -----
// Front end: takes a request beat, classifies it and builds the queue descriptor.
// Depends on lcdns_pkg.
`timescale 1ns / 1ps

module lcdns_front
(
    input  logic                start,
    input  logic                busy,
    input  logic [2:0]          cmd,
    input  logic [7:0]          value,
    input  logic [1:0]          line,
    input  logic [6:0]          column,
    output logic                push,
    output lcdns_pkg::desc_t    desc
);
    import lcdns_pkg::*;

    logic       known;
    logic [1:0] line_m1;
    logic [7:0] col_m1;
    logic [7:0] pos_addr;

    // 0x80 + 0x40*(line-1) + (column-1), all mod 256
    assign line_m1  = line - 2'd1;
    assign col_m1   = {1'b0, column} - 8'd1;
    assign pos_addr = ADDR_BASE + {line_m1, 6'b0} + col_m1;

    always_comb
    begin
        known = 1'b1;
        desc  = '0;
        case (cmd)
            CMD_INIT:    desc.is_init = 1'b1;
            CMD_BYTE:    desc.byte0 = value;
            CMD_CHAR:
            begin
                desc.rs0   = 1'b1;
                desc.byte0 = value;
            end
            CMD_GOTO:    desc.byte0 = ADDR_BASE + value;
            CMD_CLEAR:
            begin
                desc.byte0    = BYTE_CLEAR;
                desc.clr_wait = 1'b1;
            end
            CMD_CHAR_AT:
            begin
                desc.two_bytes = 1'b1;
                desc.byte0     = pos_addr;
                desc.byte1     = value;
            end
            default:     known = 1'b0;  // unused codes are taken and dropped
        endcase
    end

    assign push = start && !busy && known;

endmodule

// ----- rtl/core/lcdns_queue.sv -----
// Small register queue of request descriptors between front and back end.
// Depends on lcdns_pkg and the shared assertion macros.
`timescale 1ns / 1ps
`include "char_lcd_nibble_sequencer_macros.svh"

module lcdns_queue
#(
    parameter int DEPTH = lcdns_pkg::QUEUE_DEPTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  lcdns_pkg::desc_t    push_desc,
    input  logic                pop,
    output logic                full,
    output logic                head_valid,
    output lcdns_pkg::desc_t    head
);
    import lcdns_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    desc_t            mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign full       = (cnt_reg == CNT_W'(DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_desc;
        end
    end

    `LCDNS_ASSERT(a_no_pop_empty, !(pop && !head_valid), "queue popped while empty")
    `LCDNS_ASSERT(a_no_push_full, !(push && full && !pop), "queue pushed while full")
    `LCDNS_ASSERT(a_ptr_count, ((cnt_reg != '0) && (rd_ptr_reg == wr_ptr_reg)) |-> full, "queue pointers disagree with count")
    `LCDNS_ASSERT(a_cnt_range, cnt_reg <= CNT_W'(DEPTH), "queue count out of range")

endmodule

// ----- rtl/core/lcdns_back.sv -----
// Back end: walks the head descriptor one strobe per cycle into registered outputs.
// Depends on lcdns_pkg and the shared assertion macros.
`timescale 1ns / 1ps
`include "char_lcd_nibble_sequencer_macros.svh"

module lcdns_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  lcdns_pkg::desc_t    head,
    output logic                pop,
    output logic                strobe,
    output lcdns_pkg::strobe_t  beat,
    output logic                last
);
    import lcdns_pkg::*;

    logic [STEP_W-1:0] step_reg, step_next;
    logic              strobe_reg, strobe_next;
    logic              last_reg, last_next;
    strobe_t           beat_reg;
    strobe_t           cur;
    logic [STEP_W-1:0] last_step;
    logic              hi_half;
    logic              second;
    logic [7:0]        cur_byte;

    assign hi_half  = !step_reg[0];
    assign second   = step_reg[1];
    assign cur_byte = second ? head.byte1 : head.byte0;

    always_comb
    begin
        if (head.is_init)
        begin
            cur = init_strobe(step_reg);
        end
        else
        begin
            cur.rs          = second ? 1'b1 : head.rs0;
            cur.nibble      = hi_half ? cur_byte[7:4] : cur_byte[3:0];
            cur.wait_before = hi_half ? WAIT_BYTE_PRE : WAIT_NONE_PRE;
            cur.wait_after  = (!hi_half && !second && head.clr_wait) ? WAIT_CLEAR : WAIT_STROBE;
        end

        if (head.is_init)
        begin
            last_step = LAST_STEP_INIT;
        end
        else if (head.two_bytes)
        begin
            last_step = LAST_STEP_PAIR;
        end
        else
        begin
            last_step = LAST_STEP_BYTE;
        end
    end

    assign pop         = head_valid && (step_reg == last_step);
    assign strobe_next = head_valid;
    assign last_next   = pop;
    assign step_next   = pop ? '0 : (head_valid ? step_reg + 1'b1 : step_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= '0;
            strobe_reg <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            step_reg   <= step_next;
            strobe_reg <= strobe_next;
            last_reg   <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        beat_reg <= cur;
    end

    assign strobe = strobe_reg;
    assign last   = last_reg;
    assign beat   = beat_reg;

    `LCDNS_ASSERT_ALWAYS(a_last_has_strobe, last_reg |-> strobe_reg, "last without strobe")
    `LCDNS_ASSERT(a_step_range, step_reg <= LAST_STEP_INIT, "step counter out of range")
    `LCDNS_ASSERT(a_run_unbroken, (strobe_reg && !last_reg) |-> head_valid, "request run broken")

endmodule

// ----- rtl/core/char_lcd_nibble_sequencer.sv -----
// Top level of the character-LCD nibble sequencer (4-bit bus).
// Depends on lcdns_pkg, lcdns_front, lcdns_queue and lcdns_back.
//
//  channel   handshake          payload
//  request   start / busy       cmd, value, line, column
//  strobe    strobe             rs, nibble, wait_before_us, wait_after_us, last
//
// A request is taken when start is high and busy is low; busy means the descriptor
// queue (QUEUE_DEPTH entries) is full. The back end emits one beat per cycle from
// the queue head: init 12 beats, positioned character 4, all other commands 2.
// Beats leave via the queue, then registered outputs; unused command codes give none.
// rst_n clears queue and sequencer state asynchronously. The receiver cannot stall.
`timescale 1ns / 1ps

module char_lcd_nibble_sequencer
#(
    parameter int QUEUE_DEPTH = lcdns_pkg::QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  cmd,
    input  logic [7:0]  value,
    input  logic [1:0]  line,
    input  logic [6:0]  column,
    output logic        strobe,
    output logic        rs,
    output logic [3:0]  nibble,
    output logic [14:0] wait_before_us,
    output logic [12:0] wait_after_us,
    output logic        last
);
    import lcdns_pkg::*;

    logic    push;
    logic    pop;
    logic    full;
    logic    head_valid;
    desc_t   push_desc;
    desc_t   head;
    strobe_t beat;

    assign busy = full;

    lcdns_front u_front
    (
        .start  (start),
        .busy   (full),
        .cmd    (cmd),
        .value  (value),
        .line   (line),
        .column (column),
        .push   (push),
        .desc   (push_desc)
    );

    lcdns_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_desc  (push_desc),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head       (head)
    );

    lcdns_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .strobe     (strobe),
        .beat       (beat),
        .last       (last)
    );

    assign rs             = beat.rs;
    assign nibble         = beat.nibble;
    assign wait_before_us = beat.wait_before;
    assign wait_after_us  = beat.wait_after;

endmodule
